// ----- hdl/lss_pkg.sv -----
package lss_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int OPCODE_W  = 3;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_POP     = 3'd1,
    OP_QUERY   = 3'd2,
    OP_POPTHRU = 3'd3,
    OP_CLEAR   = 3'd4
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NOMATCH = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOAD   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  typedef struct packed {
    logic                      load;
    logic                      shift;
    logic                      push;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- hdl/lifo_stack_with_search_top.sv -----
// Channel   Handshake            Payload
// input     in_valid, in_ready   in_opcode[2:0], in_value[31:0] signed
// result    out_valid, out_ready out_status[1:0], out_found, out_count[4:0]
//
// The length of a transaction is set by the match scan: every cell compares in
// parallel, then the match bits shift up the cell chain one cell a cycle until
// the topmost match reaches the top cell or all cells have been seen.
// A new transaction is accepted only once the previous one has finished.
// Reset (rst_n low, synchronous) empties the stack and drops any pending result.
// A result waiting in the output register holds up only the final cycle of the
// next transaction; the input side is free to accept while the result waits.
module lifo_stack_with_search_top import lss_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OPCODE_W-1:0]       in_opcode,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STATUS_W-1:0]       out_status,
  output logic                      out_found,
  output logic [COUNT_W-1:0]        out_count
);

  localparam int FW = $clog2(DEPTH + 1);

  cell_ctrl_t    cell_ctrl;
  logic [FW-1:0] fill;
  logic [DEPTH:0] scan_chain;

  assign scan_chain[0] = 1'b0;

  lss_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_opcode  (in_opcode),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_found  (out_found),
    .out_count  (out_count),
    .cell_ctrl  (cell_ctrl),
    .fill       (fill),
    .scan_top   (scan_chain[DEPTH])
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lss_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cell_ctrl),
      .fill     (fill),
      .scan_in  (scan_chain[i]),
      .scan_out (scan_chain[i+1])
    );
  end

endmodule

// ----- hdl/lss_cell.sv -----
module lss_cell import lss_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0,
  localparam int FW   = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_ctrl_t    ctrl,
  input  logic [FW-1:0] fill,
  input  logic          scan_in,
  output logic          scan_out
);

  logic signed [VALUE_W-1:0] entry_r;
  logic                      scan_r;
  logic                      scan_nxt;
  logic                      live;

  assign live = (FW'(IDX) < fill);

  always_comb begin
    scan_nxt = scan_r;
    if (ctrl.load) begin
      scan_nxt = live && (entry_r == ctrl.value);
    end else if (ctrl.shift) begin
      scan_nxt = scan_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= 1'b0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && (fill == FW'(IDX))) begin
      entry_r <= ctrl.value;
    end
  end

  assign scan_out = scan_r;

endmodule

// ----- hdl/lss_ctrl.sv -----
module lss_ctrl import lss_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  localparam int FW   = $clog2(DEPTH + 1),
  localparam int CW   = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [OPCODE_W-1:0]       in_opcode,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STATUS_W-1:0]       out_status,
  output logic                      out_found,
  output logic [COUNT_W-1:0]        out_count,
  output cell_ctrl_t                cell_ctrl,
  output logic [FW-1:0]             fill,
  input  logic                      scan_top
);

  state_t                    state_r, state_nxt;
  logic [OPCODE_W-1:0]       op_r, op_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic [FW-1:0]             fill_r, fill_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic                      hit_r, hit_nxt;
  logic [FW-1:0]             pos_r, pos_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic                      out_found_r, out_found_nxt;
  logic [COUNT_W-1:0]        out_count_r, out_count_nxt;
  logic                      do_push;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    value_nxt      = value_r;
    fill_nxt       = fill_r;
    cnt_nxt        = cnt_r;
    hit_nxt        = hit_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    do_push        = 1'b0;
    cell_ctrl      = '{load: 1'b0, shift: 1'b0, push: 1'b0, value: value_r};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          value_nxt = in_value;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cell_ctrl.load = 1'b1;
        cnt_nxt        = '0;
        hit_nxt        = 1'b0;
        state_nxt      = S_SCAN;
      end
      S_SCAN: begin
        if (scan_top) begin
          hit_nxt   = 1'b1;
          pos_nxt   = FW'(DEPTH - 1) - FW'(cnt_r);
          state_nxt = S_FINISH;
        end else if (cnt_r == CW'(DEPTH - 1)) begin
          state_nxt = S_FINISH;
        end else begin
          cell_ctrl.shift = 1'b1;
          cnt_nxt         = cnt_r + 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_status_nxt = STAT_OK;
          case (op_r)
            OP_PUSH: begin
              if (fill_r == FW'(DEPTH)) begin
                out_status_nxt = STAT_FULL;
              end else begin
                do_push  = 1'b1;
                fill_nxt = fill_r + 1'b1;
              end
            end
            OP_POP: begin
              if (fill_r == '0) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                fill_nxt = fill_r - 1'b1;
              end
            end
            OP_POPTHRU: begin
              if (fill_r == '0) begin
                out_status_nxt = STAT_EMPTY;
              end else if (!hit_r) begin
                out_status_nxt = STAT_NOMATCH;
              end else begin
                fill_nxt = pos_r;
              end
            end
            OP_CLEAR: begin
              fill_nxt = '0;
            end
            default: begin
            end
          endcase
          cell_ctrl.push = do_push;
          out_found_nxt  = hit_r;
          out_count_nxt  = COUNT_W'(fill_nxt);
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      hit_r       <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    value_r      <= value_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_count  = out_count_r;
  assign fill       = fill_r;

endmodule

// ----- bench/lss_result_checker.sv -----
module lss_result_checker import lss_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [OPCODE_W-1:0]       in_opcode,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [STATUS_W-1:0]       out_status,
  input  logic                      out_found,
  input  logic [COUNT_W-1:0]        out_count,
  output int                        mismatch_count,
  output int                        awaited_count
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t            status;
    logic               found;
    logic [COUNT_W-1:0] count;
  } stack_result_t;

  logic signed [VALUE_W-1:0] cells [DEPTH_DEF];
  int                        fill;
  stack_result_t             awaited_results [$];

  function automatic stack_result_t apply_stack_op(input logic [OPCODE_W-1:0] op,
                                                   input logic signed [VALUE_W-1:0] val);
    stack_result_t res;
    int            hit_pos;
    hit_pos = -1;
    for (int i = fill - 1; i >= 0; i--) begin
      if (hit_pos < 0 && cells[i] == val) begin
        hit_pos = i;
      end
    end
    res.status = STAT_OK;
    res.found  = (hit_pos >= 0);
    case (op)
      OP_PUSH: begin
        if (fill >= DEPTH_DEF) begin
          res.status = STAT_FULL;
        end else begin
          cells[fill] = val;
          fill++;
        end
      end
      OP_POP: begin
        if (fill == 0) res.status = STAT_EMPTY;
        else fill--;
      end
      OP_POPTHRU: begin
        if (fill == 0) res.status = STAT_EMPTY;
        else if (hit_pos < 0) res.status = STAT_NOMATCH;
        else fill = hit_pos;
      end
      OP_CLEAR: begin
        fill = 0;
      end
      default: begin
      end
    endcase
    res.count = fill[COUNT_W-1:0];
    return res;
  endfunction

  initial begin
    mismatch_count = 0;
    awaited_count  = 0;
    fill           = 0;
  end

  // A result leaving at an edge always belongs to an earlier transaction, so it is
  // checked before any transaction accepted at the same edge is predicted.
  always @(posedge clk) begin
    stack_result_t want;
    if (!rst_n) begin
      fill = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with no expectation waiting: status %0d found %0d count %0d",
                 out_status, out_found, out_count);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status || out_found !== want.found ||
              out_count !== want.count) begin
            mismatch_count <= mismatch_count + 1;
          end
          if (out_status !== want.status)
            $error("status: expected %0d, actual %0d", want.status, out_status);
          if (out_found !== want.found)
            $error("found: expected %0d, actual %0d", want.found, out_found);
          if (out_count !== want.count)
            $error("count: expected %0d, actual %0d", want.count, out_count);
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_stack_op(in_opcode, in_value));
      end
    end
    awaited_count <= awaited_results.size();
  end

endmodule

// ----- bench/tb_lifo_stack_with_search_top.sv -----
module tb_lifo_stack_with_search_top import lss_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int                        RANDOM_ITEMS  = 550;
  localparam int                        HOLD_CYCLES   = 200;
  localparam int                        CYCLE_LIMIT   = 200000;
  localparam logic [OPCODE_W-1:0]       OP_RSVD_FIRST = 3'd5;
  localparam logic [OPCODE_W-1:0]       OP_RSVD_LAST  = 3'd7;
  localparam logic signed [VALUE_W-1:0] VAL_MIN       = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX       = 32'sh7fff_ffff;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [OPCODE_W-1:0]       in_opcode;
  logic signed [VALUE_W-1:0] in_value;
  logic                      out_valid;
  logic                      out_ready;
  logic [STATUS_W-1:0]       out_status;
  logic                      out_found;
  logic [COUNT_W-1:0]        out_count;

  int                        mismatch_count;
  int                        awaited_count;
  int                        cycle_count;
  int                        burst_left;
  int                        holds_asked;
  int                        holds_done;
  logic signed [VALUE_W-1:0] value_pool [8];

  lifo_stack_with_search_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_status(out_status),
    .out_found (out_found),
    .out_count (out_count)
  );

  lss_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_found     (out_found),
    .out_count     (out_count),
    .mismatch_count(mismatch_count),
    .awaited_count (awaited_count)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic signed [VALUE_W-1:0] val);
    int gap;
    @(negedge clk);
    in_valid  = 1'b1;
    in_opcode = op;
    in_value  = val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      6, 7: return $urandom;
      8: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return value_pool[$urandom_range(0, 7)];
    endcase
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_opcode(input logic push_heavy);
    int roll;
    roll = $urandom_range(0, 99);
    if (push_heavy) begin
      if (roll < 60) return OP_PUSH;
      if (roll < 70) return OP_POP;
      if (roll < 82) return OP_QUERY;
      if (roll < 94) return OP_POPTHRU;
      if (roll < 96) return OP_CLEAR;
    end else begin
      if (roll < 20) return OP_PUSH;
      if (roll < 50) return OP_POP;
      if (roll < 65) return OP_QUERY;
      if (roll < 92) return OP_POPTHRU;
      if (roll < 96) return OP_CLEAR;
    end
    return OPCODE_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
  endfunction

  // The receiver changes its stall pattern every segment; a requested hold-off keeps
  // it from taking any result transaction for a long stretch.
  initial begin
    int mode;
    int seg_len;
    out_ready  = 1'b0;
    holds_done = 0;
    forever begin
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 60);
      for (int k = 0; k < seg_len; k++) begin
        @(negedge clk);
        if (holds_done != holds_asked) begin
          out_ready = 1'b0;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
          holds_done++;
        end
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = $urandom_range(0, 1);
          2: out_ready = (k % 4 == 3);
          default: out_ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    logic push_heavy;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_opcode   = OP_PUSH;
    in_value    = '0;
    burst_left  = 0;
    holds_asked = 0;
    push_heavy  = 1'b1;
    foreach (value_pool[i]) value_pool[i] = $urandom;
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    send_item(OP_POP, 32'sd1);
    send_item(OP_POPTHRU, VAL_MAX);
    send_item(OP_QUERY, '0);
    send_item(OP_CLEAR, '1);
    for (int op = OP_RSVD_FIRST; op <= OP_RSVD_LAST; op++) begin
      send_item(OPCODE_W'(op), $urandom);
    end
    send_item(OP_PUSH, VAL_MIN);
    send_item(OP_PUSH, VAL_MAX);
    send_item(OP_PUSH, '0);
    send_item(OP_PUSH, '1);
    send_item(OP_PUSH, VAL_MAX);
    send_item(OP_QUERY, VAL_MAX);
    send_item(OP_POPTHRU, 32'sh1234_5678);
    send_item(OP_POPTHRU, VAL_MAX);
    send_item(OP_POP, '0);
    for (int i = 0; i < 14; i++) send_item(OP_PUSH, value_pool[$urandom_range(0, 7)]);
    send_item(OP_PUSH, $urandom);
    send_item(OP_POPTHRU, VAL_MIN);

    holds_asked = 1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) push_heavy = $urandom_range(0, 2) != 0;
      if (n == RANDOM_ITEMS / 2) holds_asked = 2;
      send_item(pick_opcode(push_heavy), pick_value());
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (awaited_count != 0) @(negedge clk);
    repeat (DEPTH_DEF + 8) @(negedge clk);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
